// ----- rtl/heater_fan_power_total_assert.svh -----
// assertion macros used by heater_fan_power_total.sv
`ifndef HEATER_FAN_POWER_TOTAL_ASSERT_SVH
`define HEATER_FAN_POWER_TOTAL_ASSERT_SVH
`ifndef SYNTHESIS
`define HFPT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define HFPT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define HFPT_ASSERT(label, clk, rstn, prop)
`define HFPT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/hfpt_pkg.sv -----
package hfpt_pkg;

  localparam int unsigned HEATER_CHANNELS_DEF = 8;
  localparam int unsigned FAN_CHANNELS_DEF    = 8;

  // request op codes
  localparam logic OP_HEATER = 1'b0;
  localparam logic OP_FAN    = 1'b1;

  // cubic coefficients scaled by 2^56
  localparam logic signed [32:0] COEF_A = 33'sd202287886;
  localparam logic signed [63:0] COEF_B = 64'sd256342676084;
  localparam logic signed [63:0] COEF_C = 64'sd527879735984090;
  localparam logic signed [63:0] COEF_D = 64'sd54699475627805702;
  localparam logic signed [63:0] NEG_B  = -COEF_B;
  localparam logic signed [63:0] NEG_DS = -(COEF_D >>> 24);

  localparam logic signed [48:0] OUT_OFFSET = 49'sd327680;
  localparam logic signed [48:0] TRUNC_BIAS = 49'sd65535;
  localparam logic signed [24:0] OUT_LOW    = -25'sd16;
  localparam logic signed [24:0] OUT_HIGH   = 25'sd16777215;

  typedef struct packed {
    logic signed [32:0] mul_a;
    logic signed [63:0] addend;
    logic               hi;
  } mac_req_t;

endpackage

// ----- rtl/heater_fan_power_total.sv -----
// heater and fan power total
// input channel: in_valid_i / in_stall_o with op_i, channel_i, value_i,
// end_of_batch_i; a request is taken when valid is high and stall is low
// output channel: out_valid_o / out_stall_i with total_power_o
// heater request: the table update in ST_HEAT, then ST_FIN
// fan request: the cubic runs as five multiply-add steps on one
// 33x17 multiplier with a 64-bit adder, then the table update
// request with an out-of-range channel: straight to ST_FIN, nothing stored
// in_stall_o is high while a request is being worked on
// on the last request of a batch that touched a channel the total is loaded
// into the output register at the end of the request
// if the output register still holds an untaken total, the block waits in
// its final step until the receiver takes it
// channel tables are RAMs with a valid bit per entry
// reset clears the valid bits, the total, the batch flag and the output valid
`include "heater_fan_power_total_assert.svh"
module heater_fan_power_total #(
  parameter int unsigned HEATER_CHANNELS = hfpt_pkg::HEATER_CHANNELS_DEF,
  parameter int unsigned FAN_CHANNELS    = hfpt_pkg::FAN_CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [2:0]         channel_i,
  input  logic [15:0]        value_i,
  input  logic               end_of_batch_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [24:0] total_power_o
);

  localparam int unsigned HAW = (HEATER_CHANNELS > 1) ? $clog2(HEATER_CHANNELS) : 1;
  localparam int unsigned FAW = (FAN_CHANNELS > 1) ? $clog2(FAN_CHANNELS) : 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_HEAT = 4'd1;
  localparam logic [3:0] ST_M1   = 4'd2;
  localparam logic [3:0] ST_M2   = 4'd3;
  localparam logic [3:0] ST_M3   = 4'd4;
  localparam logic [3:0] ST_M4   = 4'd5;
  localparam logic [3:0] ST_M5   = 4'd6;
  localparam logic [3:0] ST_FUPD = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]                 state_q, state_d;
  logic [2:0]                 ch_q, ch_d;
  logic [15:0]                val_q, val_d;
  logic                       eob_q, eob_d;
  logic                       touched_q, touched_d;
  logic signed [47:0]         total_q, total_d;
  logic signed [63:0]         acc_q, acc_d;
  logic signed [63:0]         opnd_q, opnd_d;
  logic [HEATER_CHANNELS-1:0] hvld_q, hvld_d;
  logic [FAN_CHANNELS-1:0]    fvld_q, fvld_d;
  logic                       out_vld_q, out_vld_d;
  logic signed [24:0]         out_q, out_d;

  logic                       in_acc;
  logic                       in_range;
  logic                       out_free;
  logic [2:0]                 ch_sel;
  logic [HAW-1:0]             h_idx, h_raddr;
  logic [FAW-1:0]             f_idx, f_raddr;
  logic [19:0]                h_rdata, h_old, h_new;
  logic [39:0]                f_rdata, f_old, f_new;
  logic signed [20:0]         h_delta;
  logic                       h_we, f_we;
  hfpt_pkg::mac_req_t         mac_req;
  logic signed [63:0]         mac_sum;
  logic signed [32:0]         opnd_lo, opnd_hi;
  logic signed [48:0]         sum_off, sum_bias;
  logic signed [32:0]         quo;
  logic                       emit_now;
  logic                       touch_st;
  logic                       out_ok;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_range = (op_i == hfpt_pkg::OP_FAN) ? (32'(channel_i) < FAN_CHANNELS)
                                               : (32'(channel_i) < HEATER_CHANNELS);
  assign out_free = !out_vld_q || !out_stall_i;

  assign ch_sel  = (state_q == ST_IDLE) ? channel_i : ch_q;
  assign h_raddr = HAW'(ch_sel);
  assign f_raddr = FAW'(ch_sel);
  assign h_idx   = HAW'(ch_q);
  assign f_idx   = FAW'(ch_q);

  hfpt_ram #(
    .WIDTH (20),
    .DEPTH (HEATER_CHANNELS)
  ) u_heater_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_idx),
    .wdata_i (h_new),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  hfpt_ram #(
    .WIDTH (40),
    .DEPTH (FAN_CHANNELS)
  ) u_fan_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_idx),
    .wdata_i (f_new),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  assign h_old   = hvld_q[h_idx] ? h_rdata : '0;
  assign f_old   = fvld_q[f_idx] ? f_rdata : '0;
  // setting times 10 as two shifts
  assign h_new   = 20'({val_q, 3'b000}) + 20'({val_q, 1'b0});
  assign h_delta = $signed({1'b0, h_new}) - $signed({1'b0, h_old});
  // zero speed gives exactly zero
  assign f_new   = (val_q == '0) ? '0 : acc_q[55:16];
  assign h_we    = (state_q == ST_HEAT);
  assign f_we    = (state_q == ST_FUPD);

  assign opnd_lo = $signed({1'b0, opnd_q[31:0]});
  assign opnd_hi = $signed({opnd_q[63], opnd_q[63:32]});

  always_comb begin
    mac_req = '0;
    unique case (state_q)
      ST_M1: begin
        mac_req.mul_a  = hfpt_pkg::COEF_A;
        mac_req.addend = hfpt_pkg::NEG_B;
      end
      ST_M2: begin
        mac_req.mul_a  = opnd_lo;
        mac_req.addend = hfpt_pkg::COEF_C;
      end
      ST_M3: begin
        mac_req.mul_a  = opnd_hi;
        mac_req.addend = acc_q;
        mac_req.hi     = 1'b1;
      end
      ST_M4: begin
        mac_req.mul_a  = opnd_lo;
        mac_req.addend = hfpt_pkg::NEG_DS;
      end
      ST_M5: begin
        mac_req.mul_a  = opnd_hi;
        mac_req.addend = acc_q;
        mac_req.hi     = 1'b1;
      end
      default: begin
        mac_req = '0;
      end
    endcase
  end

  hfpt_mac u_mac (
    .req_i   (mac_req),
    .mul_b_i ($signed({1'b0, val_q})),
    .sum_o   (mac_sum)
  );

  // total plus 5, truncated toward zero
  assign sum_off  = $signed({total_q[47], total_q}) + hfpt_pkg::OUT_OFFSET;
  assign sum_bias = sum_off + hfpt_pkg::TRUNC_BIAS;
  assign quo      = sum_off[48] ? sum_bias[48:16] : sum_off[48:16];

  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    val_d     = val_q;
    eob_d     = eob_q;
    touched_d = touched_q;
    total_d   = total_q;
    acc_d     = acc_q;
    opnd_d    = opnd_q;
    hvld_d    = hvld_q;
    fvld_d    = fvld_q;
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d  = channel_i;
          val_d = value_i;
          eob_d = end_of_batch_i;
          if (!in_range) begin
            state_d = ST_FIN;
          end else if (op_i == hfpt_pkg::OP_FAN) begin
            state_d = ST_M1;
          end else begin
            state_d = ST_HEAT;
          end
        end
      end
      ST_HEAT: begin
        total_d       = total_q + {{11{h_delta[20]}}, h_delta, 16'b0};
        hvld_d[h_idx] = 1'b1;
        touched_d     = 1'b1;
        state_d       = ST_FIN;
      end
      ST_M1: begin
        acc_d   = mac_sum;
        opnd_d  = mac_sum;
        state_d = ST_M2;
      end
      ST_M2: begin
        acc_d   = mac_sum;
        state_d = ST_M3;
      end
      ST_M3: begin
        acc_d   = mac_sum;
        opnd_d  = mac_sum >>> 24;
        state_d = ST_M4;
      end
      ST_M4: begin
        acc_d   = mac_sum;
        state_d = ST_M5;
      end
      ST_M5: begin
        acc_d   = mac_sum;
        state_d = ST_FUPD;
      end
      ST_FUPD: begin
        total_d       = total_q + {{8{f_new[39]}}, f_new} - {{8{f_old[39]}}, f_old};
        fvld_d[f_idx] = 1'b1;
        touched_d     = 1'b1;
        state_d       = ST_FIN;
      end
      ST_FIN: begin
        if (!(eob_q && touched_q)) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d = 1'b1;
          if (quo < hfpt_pkg::OUT_LOW) begin
            out_d = hfpt_pkg::OUT_LOW;
          end else if (quo > hfpt_pkg::OUT_HIGH) begin
            out_d = hfpt_pkg::OUT_HIGH;
          end else begin
            out_d = quo[24:0];
          end
          touched_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      touched_q <= 1'b0;
      total_q   <= '0;
      hvld_q    <= '0;
      fvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      touched_q <= touched_d;
      total_q   <= total_d;
      hvld_q    <= hvld_d;
      fvld_q    <= fvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    val_q  <= val_d;
    eob_q  <= eob_d;
    acc_q  <= acc_d;
    opnd_q <= opnd_d;
    out_q  <= out_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign total_power_o = out_q;

  assign emit_now = (state_q == ST_FIN) && eob_q && touched_q && out_free;
  assign touch_st = (state_q == ST_HEAT) || (state_q == ST_FUPD);
  assign out_ok   = (out_q >= hfpt_pkg::OUT_LOW) && (out_q <= hfpt_pkg::OUT_HIGH);

  `HFPT_ASSERT(a_accept_busy, clk_i, rst_ni, in_acc |=> state_q != ST_IDLE)
  `HFPT_ASSERT(a_emit_from_fin, clk_i, rst_ni, $rose(out_vld_q) |-> $past(state_q) == ST_FIN)
  `HFPT_ASSERT(a_touch_source, clk_i, rst_ni, $rose(touched_q) |-> $past(touch_st))
  `HFPT_ASSERT(a_emit_clears, clk_i, rst_ni, emit_now |=> (!touched_q && out_vld_q))
  `HFPT_ASSERT_ALWAYS(a_out_range, clk_i, out_vld_q |-> out_ok)

endmodule

// ----- rtl/hfpt_ram.sv -----
module hfpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/hfpt_mac.sv -----
module hfpt_mac (
  input  hfpt_pkg::mac_req_t  req_i,
  input  logic signed [16:0]  mul_b_i,
  output logic signed [63:0]  sum_o
);

  logic signed [49:0] prod;
  logic signed [63:0] prod_ext;
  logic signed [63:0] term;

  assign prod     = req_i.mul_a * mul_b_i;
  assign prod_ext = 64'(prod);
  // upper partial product lands 32 bits up
  assign term     = req_i.hi ? {prod_ext[31:0], 32'b0} : prod_ext;
  assign sum_o    = req_i.addend + term;

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

class power_ledger;
  localparam int HEATERS = 8;
  localparam int FANS    = 8;

  // fitted cubic terms, scaled by 2^56
  localparam longint K3 = 64'sd202287886;
  localparam longint K2 = 64'sd256342676084;
  localparam longint K1 = 64'sd527879735984090;
  localparam longint K0 = 64'sd54699475627805702;
  localparam longint OFFSET_Q16 = 64'sd327680;
  localparam longint SAT_LO = -64'sd16;
  localparam longint SAT_HI = 64'sd16777215;

  logic [19:0]        heater_w [HEATERS];
  longint             fan_q16 [FANS];
  longint             sum_q16;
  bit                 touched;
  logic signed [24:0] totals_due [$];
  int                 errors;

  function new();
    foreach (heater_w[i]) heater_w[i] = '0;
    foreach (fan_q16[i]) fan_q16[i] = 0;
    sum_q16 = 0;
    touched = 1'b0;
    errors = 0;
  endfunction

  task flag(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function longint fan_draw_q16(input logic [15:0] rpm);
    longint v;
    longint t;
    longint u;
    v = longint'(rpm);
    if (v == 0) return 0;
    t = (K3 * v - K2) * v + K1;
    u = (t >>> 24) * v - (K0 >>> 24);
    // floor toward minus infinity
    return u >>> 16;
  endfunction

  function void take_request(input logic op, input logic [2:0] ch,
                             input logic [15:0] val, input logic eob);
    logic [19:0] hw;
    longint      fw;
    longint      tot;
    if (op == hfpt_pkg::OP_HEATER) begin
      if (int'(ch) < HEATERS) begin
        hw = 20'(val * 20'd10);
        sum_q16 += (longint'(hw) - longint'(heater_w[ch])) * 65536;
        heater_w[ch] = hw;
        touched = 1'b1;
      end
    end else begin
      if (int'(ch) < FANS) begin
        fw = fan_draw_q16(val);
        sum_q16 += fw - fan_q16[ch];
        fan_q16[ch] = fw;
        touched = 1'b1;
      end
    end
    if (!eob || !touched) return;
    touched = 1'b0;
    // division truncates toward zero
    tot = (sum_q16 + OFFSET_Q16) / 65536;
    if (tot < SAT_LO) tot = SAT_LO;
    if (tot > SAT_HI) tot = SAT_HI;
    totals_due.push_back(25'(tot));
  endfunction

  task check_total(input logic signed [24:0] got);
    logic signed [24:0] want;
    if (totals_due.size() == 0) begin
      flag($sformatf("total %0d with no request pending", got));
    end else begin
      want = totals_due.pop_front();
      if (got !== want) flag($sformatf("total got %0d want %0d", got, want));
    end
  endtask
endclass

module testbench;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          REQUESTS    = 1650;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               op_i = 1'b0;
  logic [2:0]         channel_i = '0;
  logic [15:0]        value_i = '0;
  logic               end_of_batch_i = 1'b0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic signed [24:0] total_power_o;

  power_ledger ledger;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  heater_fan_power_total dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .channel_i      (channel_i),
    .value_i        (value_i),
    .end_of_batch_i (end_of_batch_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .total_power_o  (total_power_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL heater_fan_power_total");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) ledger.check_total(total_power_o);
      out_stall_i <= !steady && ($urandom_range(99) < 38);
    end
  end

  task automatic offer(input logic op, input logic [2:0] ch,
                       input logic [15:0] val, input logic eob);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      op_i <= 1'($urandom);
      channel_i <= 3'($urandom);
      value_i <= 16'($urandom);
      end_of_batch_i <= 1'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    channel_i <= ch;
    value_i <= val;
    end_of_batch_i <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.take_request(op, ch, val, eob);
  endtask

  initial begin
    int          sent;
    int          n;
    logic        op;
    logic [15:0] val;
    ledger = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer(hfpt_pkg::OP_HEATER, 3'd0, 16'hFFFF, 1'b0);
    offer(hfpt_pkg::OP_HEATER, 3'd7, 16'h0000, 1'b1);
    offer(hfpt_pkg::OP_FAN, 3'd3, 16'h0000, 1'b1);
    offer(hfpt_pkg::OP_FAN, 3'd5, 16'hFFFF, 1'b1);
    offer(hfpt_pkg::OP_HEATER, 3'd0, 16'h0000, 1'b0);
    offer(hfpt_pkg::OP_FAN, 3'd5, 16'h0000, 1'b1);
    // all fans at the slowest speed: small negative total
    for (int c = 0; c < 8; c++) offer(hfpt_pkg::OP_FAN, 3'(c), 16'd1, c == 7);
    // fraction just below zero truncates to zero
    offer(hfpt_pkg::OP_FAN, 3'd7, 16'h0000, 1'b1);
    offer(hfpt_pkg::OP_FAN, 3'd0, 16'd100, 1'b1);
    offer(hfpt_pkg::OP_HEATER, 3'd3, 16'hAAAA, 1'b0);
    offer(hfpt_pkg::OP_HEATER, 3'd4, 16'h5555, 1'b1);
    offer(hfpt_pkg::OP_FAN, 3'd2, 16'h8000, 1'b1);
    for (int c = 0; c < 8; c++) offer(hfpt_pkg::OP_FAN, 3'(c), 16'hFFFF, 1'b0);
    offer(hfpt_pkg::OP_HEATER, 3'd6, 16'hFFFF, 1'b1);

    sent = 0;
    while (sent < REQUESTS) begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        op = 1'($urandom);
        case ($urandom_range(9))
          0: val = 16'h0000;
          1: val = 16'hFFFF;
          2: val = 16'($urandom_range(1, 200));
          3: val = 16'($urandom_range(255)) << 8;
          default: val = 16'($urandom);
        endcase
        steady <= (sent >= 700 && sent < 1000);
        offer(op, 3'($urandom), val, k == n - 1);
        sent++;
      end
    end
    in_valid_i <= 1'b0;
    steady <= 1'b0;

    while (ledger.totals_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("PASS heater_fan_power_total");
    end else begin
      $display("FAIL heater_fan_power_total");
    end
    $finish;
  end
endmodule
